// ----- rtl/tas_pkg.sv -----
// tas_pkg: shared types and constants for the turnstile access sequencer.
// No dependencies; used by tas_core and turnstile_access_sequencer_top.
package tas_pkg;

  localparam int WINDOW_BITS_DEF = 14;
  localparam int TICK_W          = 14;
  localparam int PULSE_W         = 8;
  localparam int COUNT_W         = 3;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 14;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_COLLECT = 3'd1,
    PH_PASS    = 3'd2
  } phase_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_LEAVE   = 2'd1,
    CAUSE_ENTRY   = 2'd2,
    CAUSE_REVERSE = 2'd3
  } cause_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENTRY_LEFT    = 3'd0,
    REG_HOLD_MODE     = 3'd1,
    REG_LOCK_BOTH     = 3'd2,
    REG_MULTI_MODE    = 3'd3,
    REG_COLLECT_TICKS = 3'd4,
    REG_PASS_TICKS    = 3'd5,
    REG_PULSE_TICKS   = 3'd6,
    REG_MAX_PASSES    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               entry_left;
    logic               hold_mode;
    logic               lock_both;
    logic               multi_mode;
    logic [TICK_W-1:0]  collect_ticks;
    logic [TICK_W-1:0]  pass_ticks;
    logic [PULSE_W-1:0] pulse_ticks;
    logic [COUNT_W-1:0] max_passes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    entry_left:    1'b0,
    hold_mode:     1'b0,
    lock_both:     1'b1,
    multi_mode:    1'b0,
    collect_ticks: 14'd4883,
    pass_ticks:    14'd9767,
    pulse_ticks:   8'd195,
    max_passes:    3'd5
  };

  typedef struct packed {
    logic               solenoid;
    logic [COUNT_W-1:0] lamp_count;
    logic               busy_res;
  } result_t;

endpackage

// ----- rtl/tas_core.sv -----
// tas_core: sequencer state and its one-tick update.
// Depends on tas_pkg; instantiated by turnstile_access_sequencer_top.
module tas_core #(
  parameter int WINDOW_BITS = tas_pkg::WINDOW_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             button_low,
  input  logic             rest_low,
  input  logic             right_low,
  input  logic             left_low,
  input  tas_pkg::cfg_t    cfg,
  output tas_pkg::result_t res
);

  tas_pkg::phase_t                 phase_r, phase_nxt;
  tas_pkg::cause_t                 cause_r, cause_nxt;
  logic                            armed_r, armed_nxt;
  logic                            entry_r, entry_nxt;
  logic                            exit_r, exit_nxt;
  logic [tas_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [WINDOW_BITS-1:0]          wtimer_r, wtimer_nxt;
  logic [tas_pkg::PULSE_W-1:0]     ptimer_r, ptimer_nxt, pulse_dec, pulse_load;

  logic [WINDOW_BITS+tas_pkg::TICK_W-1:0] coll_ext, pass_ext;
  logic [WINDOW_BITS-1:0]                 coll_load, pass_load;
  logic btn, at_rest, ent, ext, win_end;

  assign coll_ext  = {{WINDOW_BITS{1'b0}}, cfg.collect_ticks};
  assign pass_ext  = {{WINDOW_BITS{1'b0}}, cfg.pass_ticks};
  assign coll_load = coll_ext[WINDOW_BITS-1:0];
  assign pass_load = pass_ext[WINDOW_BITS-1:0];

  assign btn     = ~button_low;
  assign at_rest = ~rest_low;
  assign ent     = cfg.entry_left ? ~left_low  : ~right_low;
  assign ext     = cfg.entry_left ? ~right_low : ~left_low;
  assign win_end = (wtimer_r <= WINDOW_BITS'(1));

  assign pulse_load = (cfg.pulse_ticks != '0) ? cfg.pulse_ticks : tas_pkg::PULSE_W'(1);
  assign pulse_dec  = ptimer_r - tas_pkg::PULSE_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    cause_nxt  = cause_r;
    armed_nxt  = armed_r;
    entry_nxt  = entry_r;
    exit_nxt   = exit_r;
    count_nxt  = count_r;
    wtimer_nxt = wtimer_r;
    ptimer_nxt = ptimer_r;

    if (ptimer_r != '0) begin
      ptimer_nxt = pulse_dec;
      if (pulse_dec == '0) begin
        if ((cause_r == tas_pkg::CAUSE_ENTRY && ent) ||
            (cause_r == tas_pkg::CAUSE_REVERSE && ext)) begin
          ptimer_nxt = pulse_load;
        end else begin
          cause_nxt = tas_pkg::CAUSE_NONE;
        end
      end
    end else begin
      unique case (phase_r)
        tas_pkg::PH_COLLECT: begin
          if (count_r >= cfg.max_passes || (!at_rest && ent)) begin
            phase_nxt  = tas_pkg::PH_PASS;
            wtimer_nxt = pass_load;
            entry_nxt  = (count_r >= cfg.max_passes) ? 1'b0 : 1'b1;
            exit_nxt   = 1'b0;
          end else if (!btn) begin
            armed_nxt = 1'b1;
            if (win_end) begin
              phase_nxt  = tas_pkg::PH_PASS;
              wtimer_nxt = pass_load;
              entry_nxt  = 1'b0;
              exit_nxt   = 1'b0;
            end else begin
              wtimer_nxt = wtimer_r - WINDOW_BITS'(1);
            end
          end else if (armed_r) begin
            armed_nxt  = 1'b0;
            if (count_r != tas_pkg::COUNT_MAX) count_nxt = count_r + 3'd1;
            wtimer_nxt = coll_load;
          end else if (win_end) begin
            phase_nxt  = tas_pkg::PH_PASS;
            wtimer_nxt = pass_load;
            entry_nxt  = 1'b0;
            exit_nxt   = 1'b0;
          end else begin
            wtimer_nxt = wtimer_r - WINDOW_BITS'(1);
          end
        end
        tas_pkg::PH_PASS: begin
          if (!at_rest && ext && !entry_r) begin
            ptimer_nxt = pulse_load;
            cause_nxt  = tas_pkg::CAUSE_REVERSE;
          end else if ((entry_r || ent) && (exit_r || ext) && at_rest) begin
            entry_nxt = 1'b0;
            exit_nxt  = 1'b0;
            if (count_r <= 3'd1) begin
              phase_nxt  = tas_pkg::PH_IDLE;
              count_nxt  = '0;
              wtimer_nxt = '0;
            end else begin
              count_nxt  = count_r - 3'd1;
              wtimer_nxt = pass_load;
            end
          end else if (win_end) begin
            phase_nxt  = tas_pkg::PH_IDLE;
            count_nxt  = '0;
            entry_nxt  = 1'b0;
            exit_nxt   = 1'b0;
            wtimer_nxt = '0;
          end else begin
            entry_nxt  = entry_r | ent;
            exit_nxt   = exit_r | ext;
            wtimer_nxt = wtimer_r - WINDOW_BITS'(1);
          end
        end
        default: begin
          phase_nxt = tas_pkg::PH_IDLE;
          if (cfg.hold_mode && btn) begin
            if (cfg.lock_both && !at_rest && ext && !entry_r) begin
              ptimer_nxt = pulse_load;
              cause_nxt  = tas_pkg::CAUSE_REVERSE;
            end else if ((entry_r || ent) && (exit_r || ext) && at_rest) begin
              entry_nxt = 1'b0;
              exit_nxt  = 1'b0;
            end else begin
              entry_nxt = entry_r | ent;
              exit_nxt  = exit_r | ext;
            end
          end else if (!at_rest && (cfg.lock_both || ent)) begin
            ptimer_nxt = pulse_load;
            cause_nxt  = cfg.lock_both ? tas_pkg::CAUSE_LEAVE : tas_pkg::CAUSE_ENTRY;
          end else if (!cfg.hold_mode) begin
            if (!btn) begin
              armed_nxt = 1'b1;
            end else if (armed_r) begin
              armed_nxt = 1'b0;
              count_nxt = 3'd1;
              if (cfg.multi_mode) begin
                phase_nxt  = tas_pkg::PH_COLLECT;
                wtimer_nxt = coll_load;
              end else begin
                phase_nxt  = tas_pkg::PH_PASS;
                wtimer_nxt = pass_load;
                entry_nxt  = 1'b0;
                exit_nxt   = 1'b0;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tas_pkg::PH_IDLE;
      cause_r  <= tas_pkg::CAUSE_NONE;
      armed_r  <= 1'b0;
      entry_r  <= 1'b0;
      exit_r   <= 1'b0;
      count_r  <= '0;
      wtimer_r <= '0;
      ptimer_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cause_r  <= cause_nxt;
      armed_r  <= armed_nxt;
      entry_r  <= entry_nxt;
      exit_r   <= exit_nxt;
      count_r  <= count_nxt;
      wtimer_r <= wtimer_nxt;
      ptimer_r <= ptimer_nxt;
    end
  end

  assign res.solenoid   = (ptimer_nxt != '0);
  assign res.lamp_count = count_nxt;
  assign res.busy_res   = (phase_nxt == tas_pkg::PH_COLLECT) || (phase_nxt == tas_pkg::PH_PASS);

endmodule

// ----- rtl/turnstile_access_sequencer_top.sv -----
// Turnstile access sequencer top level: stream ports, config registers, result register.
// Depends on tas_pkg and tas_core.
//
// One input beat is one 1.024 ms tick of the four active-low switch levels and yields
// exactly one result beat. A beat is taken every clock cycle while the result register
// is empty or being drained; the update of the sequencer state is a single combinational
// pass from the stored state and the beat, so the result is registered and appears in the
// cycle after acceptance. There is no clearing pass after reset. Configuration writes take
// effect on the next cycle and should be made while no tick is in flight.
module turnstile_access_sequencer_top #(
  parameter int WINDOW_BITS = tas_pkg::WINDOW_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // button_low, rest_low, right_low, left_low, pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // solenoid, lamp_count[2:0], busy_res, pad
  input  logic                            cfg_we,
  input  logic [tas_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tas_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tas_pkg::cfg_t    cfg_r;
  tas_pkg::result_t res;
  tas_pkg::result_t res_r;
  logic             out_valid_r;
  logic             step;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tas_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (tas_pkg::reg_idx_t'(cfg_addr))
        tas_pkg::REG_ENTRY_LEFT:    cfg_r.entry_left    <= cfg_wdata[0];
        tas_pkg::REG_HOLD_MODE:     cfg_r.hold_mode     <= cfg_wdata[0];
        tas_pkg::REG_LOCK_BOTH:     cfg_r.lock_both     <= cfg_wdata[0];
        tas_pkg::REG_MULTI_MODE:    cfg_r.multi_mode    <= cfg_wdata[0];
        tas_pkg::REG_COLLECT_TICKS: cfg_r.collect_ticks <= cfg_wdata[tas_pkg::TICK_W-1:0];
        tas_pkg::REG_PASS_TICKS:    cfg_r.pass_ticks    <= cfg_wdata[tas_pkg::TICK_W-1:0];
        tas_pkg::REG_PULSE_TICKS:   cfg_r.pulse_ticks   <= cfg_wdata[tas_pkg::PULSE_W-1:0];
        tas_pkg::REG_MAX_PASSES:    cfg_r.max_passes    <= cfg_wdata[tas_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  tas_core #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .button_low (in_tdata[0]),
    .rest_low   (in_tdata[1]),
    .right_low  (in_tdata[2]),
    .left_low   (in_tdata[3]),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.busy_res, res_r.lamp_count, res_r.solenoid};

endmodule

// ----- rtl/tas_checker.sv -----
// tas_checker: port-level checks for turnstile_access_sequencer_top, bound below.
// Depends only on the top level's ports.
module tas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // result held while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // every accepted tick yields a result beat next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick produced no result");

  // output register must not block the input while it is empty or being drained
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with free result slot");

  // lamp shows zero whenever no collect or pass phase is running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> out_tdata[3:1] == 3'd0)
    else $error("lamp lit while idle");

  // padding bits stay clear
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'd0)
    else $error("result padding not zero");

endmodule

bind turnstile_access_sequencer_top tas_checker u_tas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/tas_checker.sv -----
// tas_scoreboard: scoreboard for turnstile_access_sequencer_top. Follows register writes,
// predicts one panel reading per accepted input beat and compares each result beat.
// Depends on tas_pkg.
`timescale 1ns / 100ps
module tas_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // button_low, rest_low, right_low, left_low, pad
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,  // solenoid, lamp_count[2:0], busy_res, pad
  input  logic                           cfg_we,
  input  logic [tas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             pending
);

  tas_pkg::cfg_t                regs;
  tas_pkg::phase_t              phase;
  tas_pkg::cause_t              hammer_cause;
  logic                         armed, entered, exited;
  logic [tas_pkg::COUNT_W-1:0]  passes;
  logic [tas_pkg::TICK_W-1:0]   window_left;
  logic [tas_pkg::PULSE_W-1:0]  hammer_left;
  tas_pkg::result_t             expected_panel[$];

  task automatic fire_hammer(input tas_pkg::cause_t why);
    hammer_left = regs.pulse_ticks;
    if (hammer_left == '0) hammer_left = tas_pkg::PULSE_W'(1);
    hammer_cause = why;
  endtask

  task automatic open_window(input logic with_entry);
    phase       = tas_pkg::PH_PASS;
    window_left = regs.pass_ticks;
    entered     = with_entry;
    exited      = 1'b0;
  endtask

  task automatic close_window();
    phase       = tas_pkg::PH_IDLE;
    passes      = '0;
    entered     = 1'b0;
    exited      = 1'b0;
    window_left = '0;
  endtask

  task automatic turnstile_tick(input logic [3:0] sw, output tas_pkg::result_t panel);
    logic btn, at_rest, ent, ext;
    btn     = ~sw[0];
    at_rest = ~sw[1];
    ent     = regs.entry_left ? ~sw[3] : ~sw[2];
    ext     = regs.entry_left ? ~sw[2] : ~sw[3];
    if (hammer_left != '0) begin
      // everything else frozen while the hammer is energised
      hammer_left = hammer_left - 1'b1;
      if (hammer_left == '0) begin
        if ((hammer_cause == tas_pkg::CAUSE_ENTRY && ent) ||
            (hammer_cause == tas_pkg::CAUSE_REVERSE && ext))
          fire_hammer(hammer_cause);
        else
          hammer_cause = tas_pkg::CAUSE_NONE;
      end
    end else if (phase == tas_pkg::PH_COLLECT) begin
      if (passes >= regs.max_passes) begin
        open_window(1'b0);
      end else if (!at_rest && ent) begin
        open_window(1'b1);
      end else if (!btn) begin
        armed = 1'b1;
        if (window_left <= 1) open_window(1'b0);
        else window_left = window_left - 1'b1;
      end else if (armed) begin
        armed = 1'b0;
        if (passes != tas_pkg::COUNT_MAX) passes = passes + 1'b1;
        window_left = regs.collect_ticks;
      end else if (window_left <= 1) begin
        open_window(1'b0);
      end else begin
        window_left = window_left - 1'b1;
      end
    end else if (phase == tas_pkg::PH_PASS) begin
      if (!at_rest && ext && !entered) begin
        fire_hammer(tas_pkg::CAUSE_REVERSE);
      end else begin
        if (ent) entered = 1'b1;
        if (ext) exited = 1'b1;
        if (entered && exited && at_rest) begin
          entered = 1'b0;
          exited  = 1'b0;
          if (passes != '0) passes = passes - 1'b1;
          if (passes == '0) close_window();
          else window_left = regs.pass_ticks;
        end else if (window_left <= 1) begin
          close_window();
        end else begin
          window_left = window_left - 1'b1;
        end
      end
    end else begin
      phase = tas_pkg::PH_IDLE;
      if (regs.hold_mode && btn) begin
        if (regs.lock_both && !at_rest && ext && !entered) begin
          fire_hammer(tas_pkg::CAUSE_REVERSE);
        end else begin
          if (ent) entered = 1'b1;
          if (ext) exited = 1'b1;
          if (entered && exited && at_rest) begin
            entered = 1'b0;
            exited  = 1'b0;
          end
        end
      end else if (!at_rest && (regs.lock_both || ent)) begin
        fire_hammer(regs.lock_both ? tas_pkg::CAUSE_LEAVE : tas_pkg::CAUSE_ENTRY);
      end else if (!regs.hold_mode) begin
        if (!btn) begin
          armed = 1'b1;
        end else if (armed) begin
          armed  = 1'b0;
          passes = tas_pkg::COUNT_W'(1);
          if (regs.multi_mode) begin
            phase       = tas_pkg::PH_COLLECT;
            window_left = regs.collect_ticks;
          end else begin
            open_window(1'b0);
          end
        end
      end
    end
    panel.solenoid   = (hammer_left != '0);
    panel.lamp_count = passes;
    panel.busy_res   = (phase == tas_pkg::PH_COLLECT || phase == tas_pkg::PH_PASS);
  endtask

  always @(posedge clk) begin : watch
    tas_pkg::result_t want, got;
    if (!rst_n) begin
      regs         = tas_pkg::CFG_RESET;
      phase        = tas_pkg::PH_IDLE;
      hammer_cause = tas_pkg::CAUSE_NONE;
      armed        = 1'b0;
      entered      = 1'b0;
      exited       = 1'b0;
      passes       = '0;
      window_left  = '0;
      hammer_left  = '0;
      expected_panel.delete();
      pending      = 0;
      mismatches   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          tas_pkg::REG_ENTRY_LEFT:    regs.entry_left    = cfg_wdata[0];
          tas_pkg::REG_HOLD_MODE:     regs.hold_mode     = cfg_wdata[0];
          tas_pkg::REG_LOCK_BOTH:     regs.lock_both     = cfg_wdata[0];
          tas_pkg::REG_MULTI_MODE:    regs.multi_mode    = cfg_wdata[0];
          tas_pkg::REG_COLLECT_TICKS: regs.collect_ticks = cfg_wdata[tas_pkg::TICK_W-1:0];
          tas_pkg::REG_PASS_TICKS:    regs.pass_ticks    = cfg_wdata[tas_pkg::TICK_W-1:0];
          tas_pkg::REG_PULSE_TICKS:   regs.pulse_ticks   = cfg_wdata[tas_pkg::PULSE_W-1:0];
          tas_pkg::REG_MAX_PASSES:    regs.max_passes    = cfg_wdata[tas_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      // drain before fill: a result beat always belongs to an earlier input beat
      if (out_tvalid && out_tready) begin
        got.solenoid   = out_tdata[0];
        got.lamp_count = out_tdata[3:1];
        got.busy_res   = out_tdata[4];
        if (expected_panel.size() == 0) begin
          $display("%0t: result beat with none expected, actual sol %b lamp %0d busy %b",
                   $time, got.solenoid, got.lamp_count, got.busy_res);
          mismatches++;
        end else begin
          want = expected_panel.pop_front();
          if (got !== want) begin
            $display("%0t: expected sol %b lamp %0d busy %b, actual sol %b lamp %0d busy %b",
                     $time, want.solenoid, want.lamp_count, want.busy_res,
                     got.solenoid, got.lamp_count, got.busy_res);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        turnstile_tick(in_tdata[3:0], want);
        expected_panel.push_back(want);
      end
      pending = expected_panel.size();
    end
  end

endmodule

// ----- sim/tb_turnstile_access_sequencer_top.sv -----
// tb_turnstile_access_sequencer_top: drives switch ticks and register settings into the
// turnstile sequencer, with random idling on both sides. Depends on tas_pkg, tas_scoreboard
// and the RTL under rtl/.
`timescale 1ns / 100ps
module tb_turnstile_access_sequencer_top;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 240;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic [7:0]                     in_tdata   = '0;  // button_low, rest_low, right_low, left_low, pad
  logic                           out_tready = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [tas_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [tas_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                           in_tready, out_tvalid;
  logic [7:0]                     out_tdata;        // solenoid, lamp_count[2:0], busy_res, pad

  int            mismatches, pending;
  int            items_sent = 0;
  int            stuck      = 0;
  bit            gaps_on    = 1'b1;
  bit            long_hold  = 1'b0;
  tas_pkg::cfg_t cur        = tas_pkg::CFG_RESET;

  always #6 clk = ~clk;

  turnstile_access_sequencer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tas_scoreboard u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // result sink: short random stalls, one long hold-off on request
  initial begin : sink
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // one tick beat; rest/ent/ext are logical levels, mapped through the entry side
  task automatic tick(input bit btn, input bit rest, input bit ent, input bit ext);
    bit rgt, lft;
    rgt = cur.entry_left ? ext : ent;
    lft = cur.entry_left ? ent : ext;
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, ~lft, ~rgt, ~rest, ~btn};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_setting(input tas_pkg::cfg_t s);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= tas_pkg::reg_idx_t'(i);
      case (tas_pkg::reg_idx_t'(i))
        tas_pkg::REG_ENTRY_LEFT:    cfg_wdata <= tas_pkg::CFG_DATA_W'(s.entry_left);
        tas_pkg::REG_HOLD_MODE:     cfg_wdata <= tas_pkg::CFG_DATA_W'(s.hold_mode);
        tas_pkg::REG_LOCK_BOTH:     cfg_wdata <= tas_pkg::CFG_DATA_W'(s.lock_both);
        tas_pkg::REG_MULTI_MODE:    cfg_wdata <= tas_pkg::CFG_DATA_W'(s.multi_mode);
        tas_pkg::REG_COLLECT_TICKS: cfg_wdata <= tas_pkg::CFG_DATA_W'(s.collect_ticks);
        tas_pkg::REG_PASS_TICKS:    cfg_wdata <= tas_pkg::CFG_DATA_W'(s.pass_ticks);
        tas_pkg::REG_PULSE_TICKS:   cfg_wdata <= tas_pkg::CFG_DATA_W'(s.pulse_ticks);
        tas_pkg::REG_MAX_PASSES:    cfg_wdata <= tas_pkg::CFG_DATA_W'(s.max_passes);
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = s;
  endtask

  task automatic walk_through(input bit btn);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) tick(btn, 0, 0, 1);
    repeat ($urandom_range(1, 3)) tick(btn, 0, 1, 0);
    repeat ($urandom_range(0, 2)) tick(btn, 0, 1, 1);
    repeat ($urandom_range(1, 3)) tick(btn, 0, 0, 1);
    repeat ($urandom_range(1, 2)) tick(btn, 1, 0, 0);
    // occasionally let the pass window run out
    if ($urandom_range(0, 7) == 0 && cur.pass_ticks < 24)
      repeat (cur.pass_ticks + 1) tick(btn, 1, 0, 0);
  endtask

  task automatic random_episode();
    int presses;
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 4))
           tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      1: begin
        repeat ($urandom_range(1, 3)) tick(1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)), 1);
        tick(0, 1, 0, 0);
      end
      2: begin
        repeat ($urandom_range(1, 3)) tick(0, 0, 1, 1'($urandom_range(0, 1)));
        tick(0, 1, 0, 0);
      end
      default: begin
        presses = cur.multi_mode ? $urandom_range(1, 8) : 1;
        repeat (presses) begin
          repeat ($urandom_range(1, 2)) tick(0, 1, 0, 0);
          repeat ($urandom_range(1, 2)) tick(1, 1, 0, 0);
        end
        if (!cur.hold_mode) repeat ($urandom_range(0, 3)) tick(0, 1, 0, 0);
        repeat ($urandom_range(1, presses + 1))
          walk_through(cur.hold_mode && $urandom_range(0, 5) != 0);
      end
    endcase
  endtask

  initial begin : stimulus
    tas_pkg::cfg_t s;
    int            quota;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one authorised passage
    tick(0, 1, 0, 0); tick(1, 1, 0, 0); tick(1, 1, 0, 0); tick(0, 0, 1, 0);
    tick(0, 0, 1, 1); tick(0, 0, 0, 1); tick(0, 1, 0, 0);

    // zero timers and press limit, entry on the left, entry-only locking
    settle();
    s = '{1'b1, 1'b0, 1'b0, 1'b1, 14'd0, 14'd0, 8'd0, 3'd0};
    load_setting(s);
    tick(0, 0, 0, 1); tick(0, 0, 1, 0); tick(0, 0, 1, 0); tick(0, 1, 0, 0);
    tick(0, 1, 0, 0); tick(1, 1, 0, 0); tick(1, 1, 0, 0); tick(0, 1, 0, 0);

    // hold mode: reverse try with button held, free passage, release then leave rest
    settle();
    s = '{1'b0, 1'b1, 1'b1, 1'b0, 14'd3, 14'd5, 8'd1, 3'd7};
    load_setting(s);
    tick(1, 1, 0, 0); tick(1, 0, 0, 1); tick(1, 0, 0, 1); tick(1, 1, 0, 0);
    tick(1, 0, 1, 0); tick(1, 0, 1, 1); tick(1, 0, 0, 1); tick(1, 1, 0, 0);
    tick(0, 0, 1, 0); tick(0, 1, 0, 0);

    for (int p = 0; p < 11; p++) begin
      settle();
      if (p == 0) begin
        s     = '{1'b1, 1'b0, 1'b1, 1'b1, 14'd16383, 14'd16383, 8'd255, 3'd7};
        quota = 40;
      end else if (p == 1) begin
        s     = '{1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 14'd0, 8'd0, 3'd0};
        quota = 60;
      end else begin
        s.entry_left    = 1'($urandom_range(0, 1));
        s.hold_mode     = ($urandom_range(0, 3) == 0);
        s.lock_both     = 1'($urandom_range(0, 1));
        s.multi_mode    = 1'($urandom_range(0, 1));
        s.collect_ticks = 14'($urandom_range(0, 10));
        s.pass_ticks    = 14'($urandom_range(0, 16));
        s.pulse_ticks   = 8'($urandom_range(0, 5));
        s.max_passes    = 3'($urandom_range(0, 7));
        quota           = 115;
      end
      load_setting(s);
      if (p == 3) long_hold = 1'b1;
      if (p == 10) gaps_on = 1'b0;
      quota += items_sent;
      while (items_sent < quota) random_episode();
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
